### hdl/oses_pkg.sv
// Shared constants and types for the occupied-slot exchange sorter.
`timescale 1ns / 1ps

package oses_pkg;

  // Table capacity and stored key width.
  localparam int SLOTS     = 16;
  localparam int KEY_BITS  = 16;

  // Widths of the fields on the ports.
  localparam int KEY_IN_W  = 16;
  localparam int TAG_W     = 16;

  // Stored key width: the low KEY_BITS bits of the 16-bit input key.
  localparam int KEY_W     = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;

  // Slot index and slot count widths.
  localparam int SLOT_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = SLOT_AW + 1;

  // One table slot as it sits in the slot memory.
  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Result offered by the sequencer to the output stage.
  typedef struct packed {
    logic             valid;
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             ovf;
  } emit_t;

endpackage

### hdl/oses_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oses_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/oses_seq.sv
// Load, exchange-sort and emit sequencer around the shared key comparator.
`timescale 1ns / 1ps

module oses_seq
  import oses_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_slot_occupied,
  input  logic [KEY_IN_W-1:0] in_sort_key,
  input  logic [TAG_W-1:0]    in_record_tag,
  input  logic                in_last_slot,
  output emit_t               emit,
  input  logic                out_free
);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_FETCH_I   = 3'd1;
  localparam logic [2:0] ST_LOAD_I    = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_WB        = 3'd4;
  localparam logic [2:0] ST_EMIT_RD   = 3'd5;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [SLOT_AW-1:0] i_r, i_nxt;
  logic [SLOT_AW-1:0] j_r, j_nxt;
  logic [SLOT_AW-1:0] k_r, k_nxt;
  slot_t              held_r, held_nxt;

  logic               we;
  logic [SLOT_AW-1:0] waddr;
  slot_t              wdata;
  logic [SLOT_AW-1:0] raddr;
  logic [SLOT_W-1:0]  rdata;
  slot_t              rd_slot;

  logic [CNT_W-1:0]   i_inc, j_inc, k_inc;
  logic               swap;
  logic               accept;

  oses_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_slot = slot_t'(rdata);
  assign i_inc   = {1'b0, i_r} + CNT_W'(1);
  assign j_inc   = {1'b0, j_r} + CNT_W'(1);
  assign k_inc   = {1'b0, k_r} + CNT_W'(1);
  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;

  // Shared comparator: the held slot moves past an occupied slot with a smaller key.
  assign swap = rd_slot.occ && (held_r.key > rd_slot.key);

  // Result offered while the read data of slot k is on the memory output.
  always_comb begin
    emit.valid = (state_r == ST_EMIT_WAIT);
    emit.occ   = rd_slot.occ;
    emit.key   = rd_slot.key;
    emit.tag   = rd_slot.tag;
    emit.last  = (k_inc == count_r);
    emit.ovf   = ovf_r;
  end

  // Sequencer next-state and memory control.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    held_nxt  = held_r;
    we        = 1'b0;
    waddr     = count_r[SLOT_AW-1:0];
    wdata     = held_r;
    raddr     = i_r;

    unique case (state_r)
      ST_LOAD: begin
        wdata.occ = in_slot_occupied;
        wdata.key = in_sort_key[KEY_W-1:0];
        wdata.tag = in_record_tag;
        if (accept) begin
          if (count_r < FULL) begin
            we        = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_slot) begin
            i_nxt     = '0;
            state_nxt = ST_FETCH_I;
          end
        end
      end
      ST_FETCH_I: begin
        raddr = i_r;
        if (i_inc >= count_r) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_LOAD_I;
        end
      end
      ST_LOAD_I: begin
        // Slot i is on the memory output; start reading slot i + 1.
        raddr    = i_inc[SLOT_AW-1:0];
        held_nxt = rd_slot;
        if (rd_slot.occ) begin
          j_nxt     = i_inc[SLOT_AW-1:0];
          state_nxt = ST_SCAN;
        end else begin
          i_nxt     = i_inc[SLOT_AW-1:0];
          state_nxt = ST_FETCH_I;
        end
      end
      ST_SCAN: begin
        raddr = j_inc[SLOT_AW-1:0];
        waddr = j_r;
        if (swap) begin
          we       = 1'b1;
          held_nxt = rd_slot;
        end
        if (j_inc < count_r) begin
          j_nxt = j_inc[SLOT_AW-1:0];
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        // The held slot is the smallest key seen; it settles at position i.
        we        = 1'b1;
        waddr     = i_r;
        i_nxt     = i_inc[SLOT_AW-1:0];
        state_nxt = ST_FETCH_I;
      end
      ST_EMIT_RD: begin
        raddr     = k_r;
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        // Hold the read address so the data stays while the output is busy.
        raddr = k_r;
        if (out_free) begin
          if (emit.last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_inc[SLOT_AW-1:0];
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Index and held-slot registers.
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    held_r <= held_nxt;
  end

endmodule

### hdl/occupied_slot_exchange_sorter.sv
// Top level of the occupied-slot exchange sorter: sequencer and output register.
`timescale 1ns / 1ps

// Usage:
// Slots arrive on the in_ channel (valid/ready), one slot per transfer, in
// position order. A transfer with in_last_slot high closes the table. Slots
// beyond the table capacity are dropped and reported on out_overflow.
// The occupied slots are then sorted by ascending key with an exchange sort
// that runs on one slot memory and one shared key comparator; free slots
// keep their positions. Every loaded slot then leaves on the out_ channel in
// position order, with out_last on the final one.
// Flow: loading accepts one slot per cycle. Sorting walks the positions in
// order on the single read port of the slot memory, comparing each occupied
// position with every later occupied slot; free positions are skipped. Each
// slot is then read and held until the output register takes it. in_ready is
// low from the last slot until the last result has entered the output register.
// A stalled receiver holds the output register and pauses emission; nothing is
// lost. Synchronous reset clears the table count, the overflow flag and the
// output valid; slot contents are not cleared.
module occupied_slot_exchange_sorter
  import oses_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_slot_occupied,
  input  logic [KEY_IN_W-1:0] in_sort_key,
  input  logic [TAG_W-1:0]    in_record_tag,
  input  logic                in_last_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_occupied,
  output logic [KEY_IN_W-1:0] out_key,
  output logic [TAG_W-1:0]    out_tag,
  output logic                out_last,
  output logic                out_overflow
);

  emit_t               emit;
  logic                out_free;
  logic                out_valid_r;
  logic                occ_r;
  logic [KEY_IN_W-1:0] key_r;
  logic [TAG_W-1:0]    tag_r;
  logic                last_r;
  logic                ovf_r;

  oses_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_slot_occupied (in_slot_occupied),
    .in_sort_key      (in_sort_key),
    .in_record_tag    (in_record_tag),
    .in_last_slot     (in_last_slot),
    .emit             (emit),
    .out_free         (out_free)
  );

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit.valid && out_free) begin
      occ_r  <= emit.occ;
      key_r  <= KEY_IN_W'(emit.key);
      tag_r  <= emit.tag;
      last_r <= emit.last;
      ovf_r  <= emit.ovf;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_occupied = occ_r;
  assign out_key      = key_r;
  assign out_tag      = tag_r;
  assign out_last     = last_r;
  assign out_overflow = ovf_r;

  // Loading and emitting never overlap.
  a_load_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !emit.valid)
    else $error("result offered while loading");

  // A closing slot stops loading until the table is emitted.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_slot |=> !in_ready)
    else $error("input accepted right after the last slot");

  // A result blocked by a full output register holds its data.
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid && !out_free |=> emit.valid && $stable(emit.key) && $stable(emit.tag))
    else $error("pending result changed while stalled");

endmodule

### verif/tb_occupied_slot_exchange_sorter.sv
// Self-checking testbench for the occupied-slot exchange sorter.
`timescale 1ns / 1ps

module tb_occupied_slot_exchange_sorter
  import oses_pkg::*;
();

  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 320;

  // One sorted slot as it should leave the block.
  typedef struct packed {
    logic                occ;
    logic [KEY_IN_W-1:0] key;
    logic [TAG_W-1:0]    tag;
    logic                last;
    logic                ovf;
  } sorted_slot_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_slot_occupied;
  logic [KEY_IN_W-1:0] in_sort_key;
  logic [TAG_W-1:0]    in_record_tag;
  logic                in_last_slot;
  logic                out_valid;
  logic                out_ready;
  logic                out_occupied;
  logic [KEY_IN_W-1:0] out_key;
  logic [TAG_W-1:0]    out_tag;
  logic                out_last;
  logic                out_overflow;

  // Shadow copy of the slot table and its bookkeeping.
  slot_t        shadow_table [SLOTS];
  int           shadow_count;
  bit           shadow_ovf;
  sorted_slot_t sorted_q [$];

  int  errors;
  int  slots_sent;
  int  tables_sent;
  int  overflow_tables;
  int  slots_checked;
  int  burst_left;
  bit  holdoff_go;
  int  holdoff_left;
  int  stall_pct;
  int  stall_phase_left;

  occupied_slot_exchange_sorter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_slot_occupied (in_slot_occupied),
    .in_sort_key      (in_sort_key),
    .in_record_tag    (in_record_tag),
    .in_last_slot     (in_last_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_occupied     (out_occupied),
    .out_key          (out_key),
    .out_tag          (out_tag),
    .out_last         (out_last),
    .out_overflow     (out_overflow)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Store a slot in the shadow table; a last slot sorts and queues the whole table.
  function automatic void load_and_sort(input bit occ, input logic [KEY_IN_W-1:0] key,
                                        input logic [TAG_W-1:0] tag, input bit last);
    slot_t        tmp;
    sorted_slot_t res;
    if (shadow_count < SLOTS) begin
      shadow_table[shadow_count].occ = occ;
      shadow_table[shadow_count].key = key[KEY_W-1:0];
      shadow_table[shadow_count].tag = tag;
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (!last) return;

    // Exchange sort over occupied positions only; free slots stay put.
    for (int i = 0; i + 1 < shadow_count; i++) begin
      if (shadow_table[i].occ) begin
        for (int j = i + 1; j < shadow_count; j++) begin
          if (shadow_table[j].occ && shadow_table[i].key > shadow_table[j].key) begin
            tmp             = shadow_table[i];
            shadow_table[i] = shadow_table[j];
            shadow_table[j] = tmp;
          end
        end
      end
    end

    for (int k = 0; k < shadow_count; k++) begin
      res.occ  = shadow_table[k].occ;
      res.key  = KEY_IN_W'(shadow_table[k].key);
      res.tag  = shadow_table[k].tag;
      res.last = (k + 1 == shadow_count);
      res.ovf  = shadow_ovf;
      sorted_q.push_back(res);
    end
    tables_sent++;
    if (shadow_ovf) overflow_tables++;
    for (int k = 0; k < SLOTS; k++) shadow_table[k].occ = 1'b0;
    shadow_count = 0;
    shadow_ovf   = 1'b0;
  endfunction

  // Offer one slot, with random gaps between bursts, and wait for the transfer.
  task automatic send_slot(input bit occ, input logic [KEY_IN_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_slot_occupied <= occ;
    in_sort_key      <= key;
    in_record_tag    <= tag;
    in_last_slot     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_and_sort(occ, key, tag, last);
    slots_sent++;
  endtask

  // Pick a key: full range, a narrow range full of ties, or an extreme.
  function automatic logic [KEY_IN_W-1:0] pick_key(input int mode);
    case (mode)
      1: pick_key = KEY_IN_W'($urandom_range(3));
      2: pick_key = ($urandom_range(2) == 0) ? '0 :
                    ($urandom_range(1) == 0) ? '1 : KEY_IN_W'($urandom);
      default: pick_key = KEY_IN_W'($urandom);
    endcase
  endfunction

  // Send a table of random slots, the final one marked last.
  task automatic send_random_table(input int n_slots);
    int key_mode;
    int occ_pct;
    key_mode = $urandom_range(2);
    occ_pct  = ($urandom_range(19) == 0) ? 0 : ($urandom_range(3) == 0) ? 100 : 75;
    for (int i = 0; i < n_slots; i++) begin
      send_slot($urandom_range(99) < occ_pct, pick_key(key_mode), TAG_W'($urandom),
                i == n_slots - 1);
    end
  endtask

  // Stop offering and wait until every queued slot has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Extremes, ties, free slots, single-slot tables and a table that overflows.
  task automatic test_directed();
    // Single occupied slot at the key minimum, then a single free slot.
    send_slot(1'b1, 16'h0000, 16'hFFFF, 1'b1);
    send_slot(1'b0, 16'hFFFF, 16'h0000, 1'b1);
    // Key extremes with ties around a free slot that must not move.
    send_slot(1'b1, 16'hFFFF, 16'h0001, 1'b0);
    send_slot(1'b0, 16'h1234, 16'h0002, 1'b0);
    send_slot(1'b1, 16'h0000, 16'h0003, 1'b0);
    send_slot(1'b1, 16'hFFFF, 16'h0004, 1'b0);
    send_slot(1'b1, 16'h0000, 16'h0005, 1'b1);
    // Full table in descending key order, then a dropped slot marked last.
    for (int i = 0; i < SLOTS; i++) begin
      send_slot(i % 5 != 3, KEY_IN_W'(16'hF000 - i * 16'h0F00), TAG_W'(16'hA500 + i), 1'b0);
    end
    send_slot(1'b1, 16'h0001, 16'hDEAD, 1'b1);
    settle();
  endtask

  // Random tables: mostly small, some full, a few that overflow.
  task automatic test_random_tables();
    int start_count;
    int size_pick;
    start_count = slots_sent;
    while (slots_sent - start_count < RANDOM_ITEMS) begin
      size_pick = $urandom_range(99);
      if (size_pick < 70)      send_random_table($urandom_range(1, 8));
      else if (size_pick < 90) send_random_table($urandom_range(9, SLOTS));
      else                     send_random_table($urandom_range(SLOTS + 1, SLOTS + 6));
    end
    settle();
  endtask

  // Receiver holds off for a long stretch while tables keep arriving.
  task automatic test_output_holdoff();
    holdoff_go = 1'b1;
    send_random_table(12);
    send_random_table(SLOTS);
    send_random_table(8);
    settle();
  endtask

  // Receiver: stall density changes from phase to phase, plus an optional hold-off.
  always @(posedge clk) begin
    if (holdoff_go) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_go   = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_phase_left = $urandom_range(20, 80);
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      stall_phase_left--;
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every output transfer with the oldest queued slot.
  always @(posedge clk) begin
    sorted_slot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot occ=%b key=%h tag=%h last=%b ovf=%b", $time,
                 out_occupied, out_key, out_tag, out_last, out_overflow);
      end else begin
        want = sorted_q.pop_front();
        slots_checked++;
        if (want.occ !== out_occupied || want.key !== out_key || want.tag !== out_tag ||
            want.last !== out_last || want.ovf !== out_overflow) begin
          errors++;
          $display("%0t: expected occ=%b key=%h tag=%h last=%b ovf=%b,", $time,
                   want.occ, want.key, want.tag, want.last, want.ovf);
          $display("%0t: got      occ=%b key=%h tag=%h last=%b ovf=%b", $time,
                   out_occupied, out_key, out_tag, out_last, out_overflow);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    errors           = 0;
    slots_sent       = 0;
    tables_sent      = 0;
    overflow_tables  = 0;
    slots_checked    = 0;
    burst_left       = 0;
    holdoff_go       = 1'b0;
    holdoff_left     = 0;
    stall_pct        = 0;
    stall_phase_left = 0;
    shadow_count     = 0;
    shadow_ovf       = 1'b0;
    for (int k = 0; k < SLOTS; k++) shadow_table[k] = '0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_slot_occupied <= 1'b0;
    in_sort_key      <= '0;
    in_record_tag    <= '0;
    in_last_slot     <= 1'b0;
    out_ready        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_tables();
    test_output_holdoff();

    $display("Sent %0d slot transfers in %0d tables, %0d of them overflowing.",
             slots_sent, tables_sent, overflow_tables);
    $display("Checked %0d sorted slots under random gaps, stalls and a long hold-off.",
             slots_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
